// ----- hw/rtl/tdf_pkg.sv -----
package tdf_pkg;

  // Field widths
  localparam int TEMP_W    = 16;
  localparam int CODE_W    = 2;
  localparam int SEG_W     = 7;
  localparam int GAUGE_W   = 9;
  localparam int THR_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 2;

  // Default gauge length
  localparam int GAUGE_SEGMENTS_DEF = 9;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UNITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd1;

  // Display sources
  localparam logic [1:0] MODE_D_SURFACE = 2'd0;
  localparam logic [1:0] MODE_O_SURFACE = 2'd1;
  localparam logic [1:0] MODE_PROBE     = 2'd2;
  localparam logic [1:0] MODE_CAVITY    = 2'd3;

  // Status codes
  localparam logic [CODE_W-1:0] CODE_NUMBER = 2'd0;
  localparam logic [CODE_W-1:0] CODE_HIGH   = 2'd1;
  localparam logic [CODE_W-1:0] CODE_LOW    = 2'd2;
  localparam logic [CODE_W-1:0] CODE_DASHES = 2'd3;

  // Letter and sign patterns, bit0 = segment a
  localparam logic [SEG_W-1:0] SEG_MINUS = 7'h40;
  localparam logic [SEG_W-1:0] SEG_H     = 7'h76;
  localparam logic [SEG_W-1:0] SEG_L     = 7'h38;
  localparam logic [SEG_W-1:0] SEG_O     = 7'h3F;
  localparam logic [SEG_W-1:0] SEG_I     = 7'h06;

  // Saturation limits
  localparam logic [9:0] POS_MAX = 10'd999;
  localparam logic [6:0] NEG_MAX = 7'd99;

  typedef struct packed {
    logic       units_fahrenheit;
    logic [1:0] display_mode;
  } cfg_t;

  typedef struct packed {
    logic [SEG_W-1:0]   hundreds_segments;
    logic [SEG_W-1:0]   tens_segments;
    logic [SEG_W-1:0]   ones_segments;
    logic [GAUGE_W-1:0] gauge_bits;
    logic               celsius_icon;
    logic               fahrenheit_icon;
    logic               probe_icon;
    logic               o_surface_icon;
    logic               d_surface_icon;
    logic               cavity_icon;
    logic               bluetooth_icon;
    logic               battery_icon;
  } result_t;

  // Decimal digit to segment code
  function automatic logic [SEG_W-1:0] digit_code(input logic [3:0] d);
    logic [SEG_W-1:0] c;
    case (d)
      4'd0: c = 7'h3F;
      4'd1: c = 7'h06;
      4'd2: c = 7'h5B;
      4'd3: c = 7'h4F;
      4'd4: c = 7'h66;
      4'd5: c = 7'h6D;
      4'd6: c = 7'h7D;
      4'd7: c = 7'h07;
      4'd8: c = 7'h7F;
      4'd9: c = 7'h6F;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // Quotient by 100 for values up to 999: multiply by 41/4096
  function automatic logic [3:0] div100(input logic [9:0] v);
    logic [15:0] p;
    p = {6'd0, v} * 16'd41;
    return p[15:12];
  endfunction

  // Quotient by 10 for values up to 127: multiply by 205/2048
  function automatic logic [3:0] div10(input logic [6:0] v);
    logic [14:0] p;
    p = {8'd0, v} * 15'd205;
    return p[14:11];
  endfunction

  // Gauge threshold of segment idx for the chosen table
  function automatic logic [THR_W-1:0] gauge_threshold(input logic probe,
                                                       input logic fahr,
                                                       input logic [3:0] idx);
    logic [THR_W-1:0] first;
    logic [THR_W-1:0] step;
    case ({probe, fahr})
      2'b10:   begin first = 11'd10; step = 11'd10; end
      2'b11:   begin first = 11'd50; step = 11'd18; end
      2'b01:   begin first = 11'd86; step = 11'd72; end
      default: begin first = 11'd30; step = 11'd40; end
    endcase
    return first + step * {7'd0, idx};
  endfunction

endpackage

// ----- hw/rtl/tdf_format.sv -----
module tdf_format #(
  parameter int GAUGE_SEGMENTS = tdf_pkg::GAUGE_SEGMENTS_DEF
) (
  input  tdf_pkg::cfg_t                    cfg,
  input  logic signed [tdf_pkg::TEMP_W-1:0] temperature,
  input  logic [tdf_pkg::CODE_W-1:0]       special_code,
  input  logic                             active,
  input  logic                             bluetooth_on,
  input  logic                             battery_low,
  output tdf_pkg::result_t                 res
);
  import tdf_pkg::*;

  logic               negative;
  logic [TEMP_W-1:0]  pos_val;
  logic [TEMP_W:0]    neg_mag;
  logic [9:0]         pos_sat;
  logic [6:0]         neg_sat;
  logic [3:0]         pos_hund;
  logic [6:0]         pos_rem;
  logic [3:0]         pos_tens;
  logic [3:0]         pos_ones;
  logic [3:0]         neg_tens;
  logic [3:0]         neg_ones;
  logic [GAUGE_W-1:0] gauge;
  logic               probe;

  assign negative = temperature[TEMP_W-1];
  assign pos_val  = temperature;
  assign probe    = (cfg.display_mode == MODE_PROBE);

  // Saturate both sign paths
  assign neg_mag = {1'b1, {TEMP_W{1'b0}}} - {1'b0, pos_val};
  assign pos_sat = (pos_val > TEMP_W'(POS_MAX)) ? POS_MAX : pos_val[9:0];
  assign neg_sat = (neg_mag > (TEMP_W+1)'(NEG_MAX)) ? NEG_MAX : neg_mag[6:0];

  // Split into decimal digits by reciprocal multiplies
  always_comb begin
    logic [10:0] hund_part;
    logic [6:0]  tens_part;
    logic [6:0]  neg_tens_part;
    pos_hund      = div100(pos_sat);
    hund_part     = {7'd0, pos_hund} * 11'd100;
    pos_rem       = 7'(pos_sat - hund_part[9:0]);
    pos_tens      = div10(pos_rem);
    tens_part     = {3'd0, pos_tens} * 7'd10;
    pos_ones      = 4'(pos_rem - tens_part);
    neg_tens      = div10(neg_sat);
    neg_tens_part = {3'd0, neg_tens} * 7'd10;
    neg_ones      = 4'(neg_sat - neg_tens_part);
  end

  // Compare against each threshold in parallel
  always_comb begin
    for (int i = 0; i < GAUGE_W; i++) begin
      gauge[i] = (i < GAUGE_SEGMENTS) &&
                 ({1'b0, pos_val} >= (TEMP_W+1)'(gauge_threshold(probe,
                                                cfg.units_fahrenheit, 4'(i))));
    end
  end

  // Assemble the result
  always_comb begin
    res = '0;
    if (active) begin
      case (special_code)
        CODE_HIGH: begin
          res.hundreds_segments = SEG_MINUS;
          res.tens_segments     = SEG_H;
          res.ones_segments     = SEG_I;
        end
        CODE_LOW: begin
          res.hundreds_segments = SEG_MINUS;
          res.tens_segments     = SEG_L;
          res.ones_segments     = SEG_O;
        end
        CODE_DASHES: begin
          res.hundreds_segments = SEG_MINUS;
          res.tens_segments     = SEG_MINUS;
          res.ones_segments     = SEG_MINUS;
        end
        default: begin
          if (negative) begin
            res.hundreds_segments = SEG_MINUS;
            res.tens_segments     = digit_code(neg_tens);
            res.ones_segments     = digit_code(neg_ones);
          end else begin
            res.hundreds_segments = digit_code(pos_hund);
            res.tens_segments     = digit_code(pos_tens);
            res.ones_segments     = digit_code(pos_ones);
            res.gauge_bits        = gauge;
          end
        end
      endcase
      res.celsius_icon    = !cfg.units_fahrenheit;
      res.fahrenheit_icon = cfg.units_fahrenheit;
      if (special_code != CODE_DASHES) begin
        res.probe_icon     = (cfg.display_mode == MODE_PROBE);
        res.o_surface_icon = (cfg.display_mode == MODE_O_SURFACE);
        res.d_surface_icon = (cfg.display_mode == MODE_D_SURFACE);
        res.cavity_icon    = (cfg.display_mode == MODE_CAVITY);
      end
      res.bluetooth_icon = bluetooth_on;
      res.battery_icon   = battery_low;
    end
  end

endmodule

// ----- hw/rtl/temp_display_formatter.sv -----
// Temperature display formatter.
// Input channel (in_valid/in_ready) carries one beat per reading: a signed
// temperature, a status code and the active, bluetooth and battery flags.
// Output channel (out_valid/out_ready) carries one beat of segment codes for
// three digits, a thermometer gauge and the icon bits.
// Units and source are set through cfg_we/cfg_addr/cfg_wdata: index 0 is
// units_fahrenheit, index 1 is display_mode; other indexes are ignored.
// A beat accepted into the input register passes the formatting logic and lands
// in the output register when that register is free or being drained.
// Throughput is one beat per cycle while the receiver keeps out_ready high; the
// digit split and the parallel gauge compares sit between the two registers.
// When the receiver stalls, the output register holds its beat and the input
// register takes one more beat, then in_ready drops until out_ready returns.
// Synchronous reset empties both registers and sets Celsius, D surface.
module temp_display_formatter #(
  parameter int GAUGE_SEGMENTS = tdf_pkg::GAUGE_SEGMENTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tdf_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [tdf_pkg::CFG_DAT_W-1:0]       cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [tdf_pkg::TEMP_W-1:0]   temperature,
  input  logic [tdf_pkg::CODE_W-1:0]          special_code,
  input  logic                                active,
  input  logic                                bluetooth_on,
  input  logic                                battery_low,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tdf_pkg::SEG_W-1:0]           hundreds_segments,
  output logic [tdf_pkg::SEG_W-1:0]           tens_segments,
  output logic [tdf_pkg::SEG_W-1:0]           ones_segments,
  output logic [tdf_pkg::GAUGE_W-1:0]         gauge_bits,
  output logic                                celsius_icon,
  output logic                                fahrenheit_icon,
  output logic                                probe_icon,
  output logic                                o_surface_icon,
  output logic                                d_surface_icon,
  output logic                                cavity_icon,
  output logic                                bluetooth_icon,
  output logic                                battery_icon
);
  import tdf_pkg::*;

  cfg_t                cfg;
  logic                s1_valid;
  logic signed [TEMP_W-1:0] s1_temperature;
  logic [CODE_W-1:0]   s1_code;
  logic                s1_active;
  logic                s1_bluetooth;
  logic                s1_battery;
  logic                s1_advance;
  result_t             res_next;
  result_t             res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_UNITS: cfg.units_fahrenheit <= cfg_wdata[0];
        REG_MODE:  cfg.display_mode     <= cfg_wdata[1:0];
        default:   cfg                  <= cfg;
      endcase
    end
  end

  // Advance when the output register is free or being drained
  assign s1_advance = !out_valid || out_ready;
  assign in_ready   = !s1_valid || s1_advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_temperature <= temperature;
      s1_code        <= special_code;
      s1_active      <= active;
      s1_bluetooth   <= bluetooth_on;
      s1_battery     <= battery_low;
    end
  end

  tdf_format #(
    .GAUGE_SEGMENTS(GAUGE_SEGMENTS)
  ) u_format (
    .cfg          (cfg),
    .temperature  (s1_temperature),
    .special_code (s1_code),
    .active       (s1_active),
    .bluetooth_on (s1_bluetooth),
    .battery_low  (s1_battery),
    .res          (res_next)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      res <= res_next;
    end
  end

  assign hundreds_segments = res.hundreds_segments;
  assign tens_segments     = res.tens_segments;
  assign ones_segments     = res.ones_segments;
  assign gauge_bits        = res.gauge_bits;
  assign celsius_icon      = res.celsius_icon;
  assign fahrenheit_icon   = res.fahrenheit_icon;
  assign probe_icon        = res.probe_icon;
  assign o_surface_icon    = res.o_surface_icon;
  assign d_surface_icon    = res.d_surface_icon;
  assign cavity_icon       = res.cavity_icon;
  assign bluetooth_icon    = res.bluetooth_icon;
  assign battery_icon      = res.battery_icon;

  // A stalled beat in the input register stays there
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid)
    else $error("input register lost a stalled beat");

  // Gauge is lit only for a non-negative number, never with a minus sign
  a_gauge_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && (gauge_bits != '0) |-> hundreds_segments != SEG_MINUS)
    else $error("gauge lit with a minus sign");

  // Gauge is a thermometer code
  a_gauge_therm: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((gauge_bits & (gauge_bits + 1'b1)) == '0))
    else $error("gauge is not a thermometer code");

  // At most one source icon and at most one unit icon
  a_icons: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({probe_icon, o_surface_icon, d_surface_icon, cavity_icon})
                  && !(celsius_icon && fahrenheit_icon))
    else $error("conflicting icons");

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
  import tdf_pkg::*;

  // Spare register indexes: writes there must leave the block unchanged
  localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

  localparam int GAUGE_LEN = GAUGE_SEGMENTS_DEF;
  localparam int PHASE_ITEMS = 220;

  // Segment codes of digits 0..9, digit 0 in the low bits
  localparam logic [69:0] DIGIT_SEGS = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                        7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic [CODE_W-1:0]        special_code;
    logic                     active;
    logic                     bluetooth_on;
    logic                     battery_low;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [TEMP_W-1:0] temperature = '0;
  logic [CODE_W-1:0] special_code = CODE_NUMBER;
  logic active = 1'b0;
  logic bluetooth_on = 1'b0;
  logic battery_low = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SEG_W-1:0] hundreds_segments;
  logic [SEG_W-1:0] tens_segments;
  logic [SEG_W-1:0] ones_segments;
  logic [GAUGE_W-1:0] gauge_bits;
  logic celsius_icon;
  logic fahrenheit_icon;
  logic probe_icon;
  logic o_surface_icon;
  logic d_surface_icon;
  logic cavity_icon;
  logic bluetooth_icon;
  logic battery_icon;

  // Local copy of the unit and source registers
  logic cur_fahr = 1'b0;
  logic [1:0] cur_mode = MODE_D_SURFACE;

  result_t pending_displays[$];
  bit idle_on = 1'b1;
  int fails = 0;
  int readings_sent = 0;
  int displays_checked = 0;
  int settings_visited = 0;

  temp_display_formatter dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .temperature(temperature),
    .special_code(special_code),
    .active(active),
    .bluetooth_on(bluetooth_on),
    .battery_low(battery_low),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hundreds_segments(hundreds_segments),
    .tens_segments(tens_segments),
    .ones_segments(ones_segments),
    .gauge_bits(gauge_bits),
    .celsius_icon(celsius_icon),
    .fahrenheit_icon(fahrenheit_icon),
    .probe_icon(probe_icon),
    .o_surface_icon(o_surface_icon),
    .d_surface_icon(d_surface_icon),
    .cavity_icon(cavity_icon),
    .bluetooth_icon(bluetooth_icon),
    .battery_icon(battery_icon)
  );

  always #1 clk = ~clk;

  // Look up the segment pattern of one decimal digit
  function automatic logic [SEG_W-1:0] seg_of(int d);
    return DIGIT_SEGS[d*7 +: 7];
  endfunction

  // Gauge threshold of segment idx for the selected table
  function automatic int threshold_of(logic fahr, logic probe, int idx);
    int first;
    int step;
    if (probe) begin
      first = fahr ? 50 : 10;
      step = fahr ? 18 : 10;
    end else begin
      first = fahr ? 86 : 30;
      step = fahr ? 72 : 40;
    end
    return first + step * idx;
  endfunction

  // Compute the display for one reading under the given units and source
  function automatic result_t format_reading(reading_t r, logic fahr, logic [1:0] mode);
    result_t d;
    int tv;
    int mag;
    int v;
    d = '0;
    if (!r.active) return d;
    tv = r.temperature;
    case (r.special_code)
      CODE_HIGH: begin
        d.hundreds_segments = SEG_MINUS;
        d.tens_segments = SEG_H;
        d.ones_segments = SEG_I;
      end
      CODE_LOW: begin
        d.hundreds_segments = SEG_MINUS;
        d.tens_segments = SEG_L;
        d.ones_segments = SEG_O;
      end
      CODE_DASHES: begin
        d.hundreds_segments = SEG_MINUS;
        d.tens_segments = SEG_MINUS;
        d.ones_segments = SEG_MINUS;
      end
      default: begin
        if (tv < 0) begin
          mag = -tv;
          if (mag > 99) mag = 99;
          d.hundreds_segments = SEG_MINUS;
          d.tens_segments = seg_of(mag / 10);
          d.ones_segments = seg_of(mag % 10);
        end else begin
          for (int i = 0; i < GAUGE_LEN && i < GAUGE_W; i++) begin
            if (tv >= threshold_of(fahr, mode == MODE_PROBE, i)) d.gauge_bits[i] = 1'b1;
          end
          v = (tv > 999) ? 999 : tv;
          d.hundreds_segments = seg_of(v / 100);
          d.tens_segments = seg_of((v / 10) % 10);
          d.ones_segments = seg_of(v % 10);
        end
      end
    endcase
    d.celsius_icon = !fahr;
    d.fahrenheit_icon = fahr;
    if (r.special_code != CODE_DASHES) begin
      d.probe_icon = (mode == MODE_PROBE);
      d.o_surface_icon = (mode == MODE_O_SURFACE);
      d.d_surface_icon = (mode == MODE_D_SURFACE);
      d.cavity_icon = (mode == MODE_CAVITY);
    end
    d.bluetooth_icon = r.bluetooth_on;
    d.battery_icon = r.battery_low;
    return d;
  endfunction

  function automatic reading_t mk(int tv, logic [CODE_W-1:0] code, logic act,
                                  logic bt, logic bat);
    reading_t r;
    r.temperature = tv[TEMP_W-1:0];
    r.special_code = code;
    r.active = act;
    r.bluetooth_on = bt;
    r.battery_low = bat;
    return r;
  endfunction

  // Idle length: mostly none or short, a few long
  function automatic int gap_len();
    int p;
    if (!idle_on) return 0;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Draw a reading, biased toward gauge thresholds and saturation edges
  function automatic reading_t random_reading();
    reading_t r;
    int pick;
    int tv;
    int c;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      tv = threshold_of(cur_fahr, cur_mode == MODE_PROBE, $urandom_range(0, GAUGE_LEN - 1))
           + int'($urandom_range(0, 4)) - 2;
    end else if (pick < 60) begin
      tv = $urandom_range(0, 65535);
    end else if (pick < 75) begin
      tv = $urandom_range(0, 1200);
    end else if (pick < 90) begin
      tv = -int'($urandom_range(0, 150));
    end else begin
      case ($urandom_range(0, 5))
        0: tv = 32767;
        1: tv = -32768;
        2: tv = 999;
        3: tv = 1000;
        4: tv = -99;
        default: tv = -100;
      endcase
    end
    c = $urandom_range(0, 9);
    r = mk(tv, (c < 7) ? CODE_NUMBER : (c == 7) ? CODE_HIGH : (c == 8) ? CODE_LOW : CODE_DASHES,
           $urandom_range(0, 99) < 88, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    return r;
  endfunction

  // Send one reading beat and queue its display on acceptance
  task automatic send_reading(reading_t r);
    int gap;
    gap = gap_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    temperature = r.temperature;
    special_code = r.special_code;
    active = r.active;
    bluetooth_on = r.bluetooth_on;
    battery_low = r.battery_low;
    do @(posedge clk); while (!in_ready);
    pending_displays.push_back(format_reading(r, cur_fahr, cur_mode));
    readings_sent++;
  endtask

  // Drop valid and wait until every queued display has come out
  task automatic settle_outputs();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_displays.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register and mirror it locally
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_UNITS) cur_fahr = val[0];
    else if (idx == REG_MODE) cur_mode = val;
  endtask

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // Check each display beat against the oldest queued one
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && out_valid && out_ready) begin
      got.hundreds_segments = hundreds_segments;
      got.tens_segments = tens_segments;
      got.ones_segments = ones_segments;
      got.gauge_bits = gauge_bits;
      got.celsius_icon = celsius_icon;
      got.fahrenheit_icon = fahrenheit_icon;
      got.probe_icon = probe_icon;
      got.o_surface_icon = o_surface_icon;
      got.d_surface_icon = d_surface_icon;
      got.cavity_icon = cavity_icon;
      got.bluetooth_icon = bluetooth_icon;
      got.battery_icon = battery_icon;
      if (pending_displays.size() == 0) begin
        $error("display beat with nothing queued");
        fails++;
      end else begin
        want = pending_displays.pop_front();
        compare_field("hundreds_segments", 16'(want.hundreds_segments),
                      16'(got.hundreds_segments));
        compare_field("tens_segments", 16'(want.tens_segments), 16'(got.tens_segments));
        compare_field("ones_segments", 16'(want.ones_segments), 16'(got.ones_segments));
        compare_field("gauge_bits", 16'(want.gauge_bits), 16'(got.gauge_bits));
        compare_field("celsius_icon", 16'(want.celsius_icon), 16'(got.celsius_icon));
        compare_field("fahrenheit_icon", 16'(want.fahrenheit_icon),
                      16'(got.fahrenheit_icon));
        compare_field("probe_icon", 16'(want.probe_icon), 16'(got.probe_icon));
        compare_field("o_surface_icon", 16'(want.o_surface_icon),
                      16'(got.o_surface_icon));
        compare_field("d_surface_icon", 16'(want.d_surface_icon),
                      16'(got.d_surface_icon));
        compare_field("cavity_icon", 16'(want.cavity_icon), 16'(got.cavity_icon));
        compare_field("bluetooth_icon", 16'(want.bluetooth_icon),
                      16'(got.bluetooth_icon));
        compare_field("battery_icon", 16'(want.battery_icon), 16'(got.battery_icon));
        displays_checked++;
      end
    end
  end

  // Toggle out_ready between ready bursts and random stalls
  initial begin
    int hold;
    int g;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (out_ready) begin
        g = gap_len();
        if (g > 0) begin
          out_ready = 1'b0;
          hold = g - 1;
        end else begin
          hold = $urandom_range(0, 6);
        end
      end else begin
        out_ready = 1'b1;
        hold = $urandom_range(0, 10);
      end
    end
  end

  // Digit extremes, saturation, status codes and an inactive device
  task automatic test_directed_formats();
    send_reading(mk(0, CODE_NUMBER, 1, 0, 0));
    send_reading(mk(9, CODE_NUMBER, 1, 0, 0));
    send_reading(mk(10, CODE_NUMBER, 1, 0, 0));
    send_reading(mk(99, CODE_NUMBER, 1, 0, 0));
    send_reading(mk(100, CODE_NUMBER, 1, 0, 0));
    send_reading(mk(999, CODE_NUMBER, 1, 0, 0));
    send_reading(mk(1000, CODE_NUMBER, 1, 0, 0));
    send_reading(mk(32767, CODE_NUMBER, 1, 1, 0));
    send_reading(mk(-1, CODE_NUMBER, 1, 0, 1));
    send_reading(mk(-10, CODE_NUMBER, 1, 0, 0));
    send_reading(mk(-99, CODE_NUMBER, 1, 0, 0));
    send_reading(mk(-100, CODE_NUMBER, 1, 0, 0));
    send_reading(mk(-32768, CODE_NUMBER, 1, 0, 0));
    send_reading(mk(500, CODE_HIGH, 1, 0, 0));
    send_reading(mk(-5, CODE_LOW, 1, 1, 1));
    send_reading(mk(500, CODE_DASHES, 1, 1, 0));
    send_reading(mk(500, CODE_NUMBER, 0, 1, 1));
    send_reading(mk(350, CODE_NUMBER, 1, 0, 0));
    send_reading(mk(349, CODE_NUMBER, 1, 0, 0));
    send_reading(mk(30, CODE_NUMBER, 1, 1, 1));
    settle_outputs();
  endtask

  // Fahrenheit probe table edges and cleared source icons
  task automatic test_units_and_source();
    write_reg(REG_UNITS, 2'd1);
    write_reg(REG_MODE, MODE_PROBE);
    settings_visited++;
    send_reading(mk(194, CODE_NUMBER, 1, 0, 0));
    send_reading(mk(193, CODE_NUMBER, 1, 0, 0));
    send_reading(mk(194, CODE_DASHES, 1, 0, 1));
    settle_outputs();
  endtask

  // Spare indexes do nothing; units keeps only its low bit
  task automatic test_register_masking();
    write_reg(REG_SPARE2, 2'd3);
    write_reg(REG_SPARE3, 2'd0);
    send_reading(mk(120, CODE_NUMBER, 1, 0, 0));
    settle_outputs();
    write_reg(REG_UNITS, 2'd2);
    write_reg(REG_MODE, MODE_CAVITY);
    settings_visited++;
    send_reading(mk(120, CODE_NUMBER, 1, 0, 0));
    send_reading(mk(120, CODE_HIGH, 1, 1, 0));
    settle_outputs();
  endtask

  // Random readings over every unit and source setting
  task automatic test_random_settings();
    logic [1:0] modes[8];
    logic units[8];
    modes = '{MODE_D_SURFACE, MODE_O_SURFACE, MODE_PROBE, MODE_PROBE,
              MODE_CAVITY, MODE_CAVITY, MODE_D_SURFACE, MODE_O_SURFACE};
    units = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_UNITS, {1'b0, units[ph]});
      write_reg(REG_MODE, modes[ph]);
      if (ph % 3 == 1) write_reg(REG_SPARE2, 2'($urandom_range(0, 3)));
      settings_visited++;
      idle_on = (ph % 3 != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold off the sender until the pipeline has emptied
        if (ph == 2 && n == PHASE_ITEMS / 2) settle_outputs();
        send_reading(random_reading());
      end
      settle_outputs();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_formats();
    test_units_and_source();
    test_register_masking();
    test_random_settings();
    settle_outputs();
    repeat (8) @(posedge clk);
    if (pending_displays.size() != 0) begin
      $error("%0d displays never came out", pending_displays.size());
      fails++;
    end
    $display("Covered %0d readings and %0d display beats over %0d unit/source settings,",
             readings_sent, displays_checked, settings_visited + 1);
    $display("including saturation, status patterns, gauge edges and spare register writes.");
    if (fails == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Stop a run that hangs
  initial begin
    #2000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
